>>> design/edr_pkg.sv
`timescale 1ns / 1ps

package edr_pkg;

   localparam logic [1:0] REQ_LEFT   = 2'd0;
   localparam logic [1:0] REQ_RIGHT  = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   localparam int RATIO_W = 23;
   localparam int OUT_LEN_W = 7;
   localparam logic [RATIO_W-1:0] PERCENT_Q16 = 23'd6553600;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
   } edr_req_type;

   typedef struct packed {
      logic [RATIO_W-1:0]   ratio_q16;
      logic [OUT_LEN_W-1:0] distance;
      logic [OUT_LEN_W-1:0] longer_length;
      logic                 overflow;
   } edr_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_CELL,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } edr_state_type;

endpackage

>>> design/edit_distance_ratio.sv
`timescale 1ns / 1ps
// The block accepts one character load per cycle while idle and stalls requests otherwise.
// A finish transaction with both strings nonempty initialises the row memory and walks the
// table; with one string empty the walk is skipped, and with both empty so is the divide.
// The dynamic program walks one table cell per cycle, then one restoring divider step
// produces one quotient bit per cycle. Reset clears the string lengths, the overflow
// flag and the result channel; the character and row memories are left as they are.

module edit_distance_ratio #(
   parameter int MAX_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  edr_pkg::edr_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output edr_pkg::edr_rsp_type rsp_data
);

   import edr_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int NUM_W = RATIO_W + CNT_W;
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [7:0] left_mem [MAX_LEN];
   logic [7:0] right_mem [MAX_LEN];
   logic [CNT_W-1:0] row_mem [MAX_LEN+1];

   edr_state_type state_ff, state_in;
   logic [CNT_W-1:0] lcnt_ff, lcnt_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] diag_ff, diag_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0] longer_ff, longer_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   edr_rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0] lrd_ff;
   logic [7:0] rrd_ff;
   logic [CNT_W-1:0] rowrd_ff;

   logic lmem_we, rmem_we, lmem_re;
   logic [IDX_W-1:0] lmem_raddr, rmem_raddr;
   logic row_we;
   logic [CNT_W-1:0] row_waddr, row_wdata, row_raddr;

   logic req_take;
   logic cost;
   logic [CNT_W:0] up1, ins1, sub1, best_w;
   logic [CNT_W-1:0] best;
   logic [CNT_W:0] trial;
   logic ge;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      cost = (lrd_ff != rrd_ff);
      up1 = {1'b0, rowrd_ff} + 1'b1;
      ins1 = {1'b0, left_ff} + 1'b1;
      sub1 = {1'b0, diag_ff} + {{CNT_W{1'b0}}, cost};
      best_w = up1;
      if (ins1 < best_w) begin
         best_w = ins1;
      end
      if (sub1 < best_w) begin
         best_w = sub1;
      end
      best = best_w[CNT_W-1:0];
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge = (trial >= {1'b0, longer_ff});
   end

   always_comb begin
      state_in = state_ff;
      lcnt_in = lcnt_ff;
      rcnt_in = rcnt_ff;
      ovf_in = ovf_ff;
      i_in = i_ff;
      j_in = j_ff;
      diag_in = diag_ff;
      left_in = left_ff;
      dist_in = dist_ff;
      longer_in = longer_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lmem_we = 1'b0;
      rmem_we = 1'b0;
      lmem_re = 1'b0;
      lmem_raddr = i_ff[IDX_W-1:0];
      rmem_raddr = j_ff[IDX_W-1:0];
      row_we = 1'b0;
      row_waddr = j_ff;
      row_wdata = j_ff;
      row_raddr = CNT_W'(j_ff + 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_data.req_type)
                  REQ_LEFT: begin
                     if (lcnt_ff < CNT_W'(MAX_LEN)) begin
                        lmem_we = 1'b1;
                        lcnt_in = CNT_W'(lcnt_ff + 1'b1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  REQ_RIGHT: begin
                     if (rcnt_ff < CNT_W'(MAX_LEN)) begin
                        rmem_we = 1'b1;
                        rcnt_in = CNT_W'(rcnt_ff + 1'b1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  REQ_FINISH: begin
                     longer_in = (lcnt_ff > rcnt_ff) ? lcnt_ff : rcnt_ff;
                     j_in = '0;
                     i_in = '0;
                     if (lcnt_ff == '0 || rcnt_ff == '0) begin
                        dist_in = lcnt_ff | rcnt_ff;
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            row_we = 1'b1;
            if (j_ff == rcnt_ff) begin
               state_in = ST_ROW;
            end else begin
               j_in = CNT_W'(j_ff + 1'b1);
            end
         end
         ST_ROW: begin
            lmem_re = 1'b1;
            rmem_raddr = '0;
            row_raddr = CNT_W'(1);
            row_we = 1'b1;
            row_waddr = '0;
            row_wdata = CNT_W'(i_ff + 1'b1);
            diag_in = i_ff;
            left_in = CNT_W'(i_ff + 1'b1);
            j_in = '0;
            state_in = ST_CELL;
         end
         ST_CELL: begin
            row_we = 1'b1;
            row_waddr = CNT_W'(j_ff + 1'b1);
            row_wdata = best;
            diag_in = rowrd_ff;
            left_in = best;
            rmem_raddr = IDX_W'(j_ff + 1'b1);
            row_raddr = CNT_W'(j_ff + 2'd2);
            if (CNT_W'(j_ff + 1'b1) == rcnt_ff) begin
               if (CNT_W'(i_ff + 1'b1) == lcnt_ff) begin
                  dist_in = best;
                  state_in = ST_MUL;
               end else begin
                  i_in = CNT_W'(i_ff + 1'b1);
                  state_in = ST_ROW;
               end
            end else begin
               j_in = CNT_W'(j_ff + 1'b1);
            end
         end
         ST_MUL: begin
            rem_in = '0;
            step_in = '0;
            if (longer_ff == '0) begin
               num_in = NUM_W'(PERCENT_Q16);
               state_in = ST_DONE;
            end else begin
               num_in = NUM_W'(PERCENT_Q16) * NUM_W'(longer_ff - dist_ff);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = CNT_W'(trial - {1'b0, longer_ff});
            end else begin
               rem_in = trial[CNT_W-1:0];
            end
            num_in = {num_ff[NUM_W-2:0], ge};
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.ratio_q16 = num_ff[RATIO_W-1:0];
               rsp_data_in.distance = OUT_LEN_W'(dist_ff);
               rsp_data_in.longer_length = OUT_LEN_W'(longer_ff);
               rsp_data_in.overflow = ovf_ff;
               rsp_valid_in = 1'b1;
               lcnt_in = '0;
               rcnt_in = '0;
               ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lcnt_ff <= '0;
         rcnt_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff <= lcnt_in;
         rcnt_ff <= rcnt_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
      dist_ff <= dist_in;
      longer_ff <= longer_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (lmem_we) begin
         left_mem[lcnt_ff[IDX_W-1:0]] <= req_data.char_code;
      end
      if (lmem_re) begin
         lrd_ff <= left_mem[lmem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rmem_we) begin
         right_mem[rcnt_ff[IDX_W-1:0]] <= req_data.char_code;
      end
      rrd_ff <= right_mem[rmem_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      rowrd_ff <= row_mem[row_raddr];
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("Result appeared without a completed computation.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      lcnt_ff <= CNT_W'(MAX_LEN) && rcnt_ff <= CNT_W'(MAX_LEN))
      else $error("String length exceeds the store depth.");

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CELL |-> (i_ff < lcnt_ff && j_ff < rcnt_ff))
      else $error("Table walk left the loaded strings.");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> dist_ff <= longer_ff)
      else $error("Distance exceeds the longer length.");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_DONE) |->
         (lcnt_ff == '0 && rcnt_ff == '0 && !ovf_ff))
      else $error("Strings not cleared after a result was issued.");

endmodule

>>> tb/edr_result_checker.sv
`timescale 1ns / 1ps

module edr_result_checker #(
   parameter int MAX_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  edr_pkg::edr_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  edr_pkg::edr_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   results_checked,
   output int                   outstanding
);
   import edr_pkg::*;

   logic [7:0]  left_text [MAX_LEN];
   logic [7:0]  right_text [MAX_LEN];
   int          left_len;
   int          right_len;
   logic        dropped_char;
   edr_rsp_type awaited_results[$];
   edr_rsp_type oldest;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic edr_rsp_type score_strings();
      int prev_row [MAX_LEN+1];
      int cur_row [MAX_LEN+1];
      int best;
      int sub;
      int edit_cost;
      int longer;
      longint unsigned ratio;
      edr_rsp_type r;
      for (int j = 0; j <= MAX_LEN; j++) begin
         prev_row[j] = j;
         cur_row[j] = 0;
      end
      for (int i = 0; i < left_len; i++) begin
         cur_row[0] = i + 1;
         for (int j = 0; j < right_len; j++) begin
            best = prev_row[j+1] + 1;
            if (cur_row[j] + 1 < best) begin
               best = cur_row[j] + 1;
            end
            sub = prev_row[j] + ((left_text[i] == right_text[j]) ? 0 : 1);
            if (sub < best) begin
               best = sub;
            end
            cur_row[j+1] = best;
         end
         prev_row = cur_row;
      end
      edit_cost = prev_row[right_len];
      longer = (left_len > right_len) ? left_len : right_len;
      if (longer == 0) begin
         ratio = 64'(PERCENT_Q16);
      end else begin
         ratio = 64'(PERCENT_Q16) * 64'(longer - edit_cost);
         ratio = ratio / 64'(longer);
      end
      r.ratio_q16 = RATIO_W'(ratio);
      r.distance = OUT_LEN_W'(edit_cost);
      r.longer_length = OUT_LEN_W'(longer);
      r.overflow = dropped_char;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         left_len = 0;
         right_len = 0;
         dropped_char = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result transaction with no request waiting for it");
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_data.ratio_q16 !== oldest.ratio_q16) begin
                  report_mismatch($sformatf("ratio_q16 got %0d, expected %0d",
                                            rsp_data.ratio_q16, oldest.ratio_q16));
               end
               if (rsp_data.distance !== oldest.distance) begin
                  report_mismatch($sformatf("distance got %0d, expected %0d",
                                            rsp_data.distance, oldest.distance));
               end
               if (rsp_data.longer_length !== oldest.longer_length) begin
                  report_mismatch($sformatf("longer_length got %0d, expected %0d",
                                            rsp_data.longer_length, oldest.longer_length));
               end
               if (rsp_data.overflow !== oldest.overflow) begin
                  report_mismatch($sformatf("overflow got %0b, expected %0b",
                                            rsp_data.overflow, oldest.overflow));
               end
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.req_type)
               REQ_LEFT: begin
                  if (left_len < MAX_LEN) begin
                     left_text[left_len] = req_data.char_code;
                     left_len++;
                  end else begin
                     dropped_char = 1'b1;
                  end
               end
               REQ_RIGHT: begin
                  if (right_len < MAX_LEN) begin
                     right_text[right_len] = req_data.char_code;
                     right_len++;
                  end else begin
                     dropped_char = 1'b1;
                  end
               end
               REQ_FINISH: begin
                  awaited_results.insert(awaited_results.size(), score_strings());
                  left_len = 0;
                  right_len = 0;
                  dropped_char = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      outstanding <= awaited_results.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import edr_pkg::*;

   localparam int MAX_LEN = 64;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 850;
   localparam int QUIET_FROM = 750;
   localparam int HOLD_AT = 250;
   localparam int DRAIN_AT = 500;
   localparam int HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   edr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   edr_rsp_type rsp_data;

   int   mismatch_count;
   int   results_checked;
   int   outstanding;
   int   cycle_count = 0;
   int   tx_sent = 0;
   int   overflow_pairs = 0;
   int   longest = 0;
   int   hold_requests = 0;
   int   holds_served = 0;
   logic quiet = 1'b0;
   logic drained = 1'b0;
   logic [7:0] left_q[$];
   logic [7:0] right_q[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   edit_distance_ratio #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   edr_result_checker #(
      .MAX_LEN(MAX_LEN)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .mismatch_count(mismatch_count),
      .results_checked(results_checked),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, outstanding);
         $display("status: fail");
         $finish;
      end
   end

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer(input logic [1:0] kind, input logic [7:0] code);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         pause_sender($urandom_range(1, 13));
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: kind, char_code: code};
      do @(posedge clock); while (req_stall);
      if (kind != REQ_UNUSED) begin
         tx_sent++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_queues(input int noise_pct);
      int li;
      int ri;
      li = 0;
      ri = 0;
      if (left_q.size() > MAX_LEN || right_q.size() > MAX_LEN) begin
         overflow_pairs++;
      end
      if (left_q.size() > longest) begin
         longest = left_q.size();
      end
      if (right_q.size() > longest) begin
         longest = right_q.size();
      end
      while (li < left_q.size() || ri < right_q.size()) begin
         if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
            offer(REQ_UNUSED, 8'($urandom_range(0, 255)));
         end
         if (ri >= right_q.size() || (li < left_q.size() && $urandom_range(0, 1) == 0)) begin
            offer(REQ_LEFT, left_q[li]);
            li++;
         end else begin
            offer(REQ_RIGHT, right_q[ri]);
            ri++;
         end
      end
      offer(REQ_FINISH, 8'($urandom_range(0, 255)));
      left_q.delete();
      right_q.delete();
   endtask

   task automatic load_text(input string lhs, input string rhs);
      for (int i = 0; i < lhs.len(); i++) begin
         left_q.insert(left_q.size(), lhs[i]);
      end
      for (int i = 0; i < rhs.len(); i++) begin
         right_q.insert(right_q.size(), rhs[i]);
      end
      send_queues(0);
   endtask

   function automatic logic [7:0] pick_char(input int alphabet);
      if (alphabet == 1) begin
         return 8'h61 + 8'($urandom_range(0, 2));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_length(input int shape);
      if (shape < 3) begin
         return $urandom_range(60, 70);
      end
      if (shape < 10) begin
         return $urandom_range(9, MAX_LEN);
      end
      return $urandom_range(0, 8);
   endfunction

   // Pairs are mostly short; the edited-copy shape keeps distances small.
   task automatic random_pair();
      int shape;
      int alphabet;
      int llen;
      int rlen;
      int pos;
      shape = $urandom_range(0, 99);
      alphabet = $urandom_range(0, 2);
      llen = pick_length(shape);
      for (int i = 0; i < llen; i++) begin
         left_q.insert(left_q.size(), pick_char(alphabet));
      end
      if (alphabet == 2) begin
         right_q = left_q;
         repeat ($urandom_range(0, 3)) begin
            pos = $urandom_range(0, right_q.size());
            case ($urandom_range(0, 2))
               0: right_q.insert(pos, pick_char(0));
               1: begin
                  if (pos < right_q.size()) begin
                     right_q.delete(pos);
                  end
               end
               default: begin
                  if (pos < right_q.size()) begin
                     right_q[pos] = pick_char(0);
                  end
               end
            endcase
         end
      end else begin
         rlen = pick_length(shape);
         for (int i = 0; i < rlen; i++) begin
            right_q.insert(right_q.size(), pick_char(alphabet));
         end
      end
      send_queues(4);
   endtask

   initial begin
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_text("", "");
      load_text("ab", "");
      load_text("", "q");
      load_text("xy", "xy");
      left_q.insert(left_q.size(), 8'h00);
      left_q.insert(left_q.size(), 8'hFF);
      right_q.insert(right_q.size(), 8'hFF);
      right_q.insert(right_q.size(), 8'h00);
      send_queues(0);
      offer(REQ_UNUSED, 8'hA5);
      load_text("abc", "ca");

      while (tx_sent < ITEM_TARGET) begin
         if (hold_requests == 0 && tx_sent >= HOLD_AT) begin
            hold_requests <= 1;
         end
         if (!drained && tx_sent >= DRAIN_AT) begin
            drained = 1'b1;
            drain_results();
         end
         if (tx_sent >= QUIET_FROM) begin
            quiet <= 1'b1;
         end
         random_pair();
      end

      drain_results();
      repeat (100) @(posedge clock);

      $display("run covered %0d request transactions and %0d checked results,",
               tx_sent, results_checked);
      $display("with %0d overflowing pairs and strings up to %0d characters long",
               overflow_pairs, longest);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
